FILE: rtl/bpfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bpfa_pkg;

  // Field widths fixed by the request and result formats.
  localparam int ACT_W   = 3;
  localparam int PAGE_W  = 16;
  localparam int LIMIT_W = 17;

  // One past the highest page index that a request can name.
  localparam logic [LIMIT_W-1:0] PAGE_SPAN = 17'h10000;

  // Request action codes.
  localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MARK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FIND  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted request
    logic rd;        // issue a bitmap word read
    logic rd_next;   // read the following word and advance the scan pointer
    logic commit;    // write back, update the count and load the result
    logic clr_step;  // write one all-used word of the reset fill
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the reset fill is at its last word
    logic scan;      // the held request is a search
    logic hit;       // the current word holds a free candidate page
    logic more;      // the search range continues past the current word
  } dp_status_t;

endpackage

FILE: rtl/bpfa_ram.sv
// Generic simple dual-port RAM: one write port and one registered read port.
// Standalone; no package dependency.
module bpfa_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bpfa_dp.sv
// Datapath of the page frame allocator: bitmap RAM, request and scan registers,
// free-bit search over one word, used-page count and result registers. Uses bpfa_pkg.
module bpfa_dp #(
  parameter int NUM_PAGES = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bpfa_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  logic [bpfa_pkg::ACT_W-1:0]       in_action,
  input  logic [bpfa_pkg::PAGE_W-1:0]      in_page_index,
  input  logic [bpfa_pkg::LIMIT_W-1:0]     in_range_end,
  input  bpfa_pkg::dp_cmd_t                cmd,
  output bpfa_pkg::dp_status_t             st,
  output logic [bpfa_pkg::PAGE_W-1:0]      out_found_page,
  output logic                             out_found,
  output logic                             out_page_is_used,
  output logic [bpfa_pkg::LIMIT_W-1:0]     out_used_count
);
  import bpfa_pkg::*;

  // WORD_BITS is a power of two; a page splits into a word index and a bit index.
  localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WW        = LIMIT_W - BIT_W;
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);
  localparam logic [LIMIT_W-1:0] PG_CAP =
    (NUM_PAGES < 65536) ? LIMIT_W'(NUM_PAGES) : PAGE_SPAN;

  logic [ACT_W-1:0]   act_r;
  logic [PAGE_W-1:0]  start_r;
  logic [LIMIT_W-1:0] hi_r;
  logic               start_ok_r;
  logic [WW-1:0]      w_r, w_nxt;
  logic [LIMIT_W-1:0] lim_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]      clr_r;

  logic [PAGE_W-1:0]    found_page_r;
  logic                 found_r;
  logic                 used_r;
  logic [LIMIT_W-1:0]   count_r;

  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] wr_word;
  logic [BIT_W-1:0]     hit_idx;
  logic                 hit;
  logic                 more;
  logic [LIMIT_W-1:0]   hit_page;
  logic                 wr_ok;

  logic [LIMIT_W-1:0] stop;
  logic [LIMIT_W-1:0] end_sel;
  logic [LIMIT_W-1:0] hi_a;
  logic [LIMIT_W-1:0] hi_in;
  logic [PAGE_W-1:0]  start_in;

  logic [WW-1:0]      sw;
  logic [WW-1:0]      hi_w;
  logic [BIT_W-1:0]   sb;
  logic [BIT_W-1:0]   hb;
  logic               at_start;
  logic               w_below;
  logic               w_at;
  logic [LIMIT_W:0]   next_base;

  logic               page_ok;
  logic               page_bit;
  logic               q_used;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;

  // Search bounds of a new request: the scan stops below min(end, limit - 1, storage).
  always_comb begin
    stop     = (lim_r == '0) ? '0 : lim_r - LIMIT_W'(1);
    end_sel  = (in_action == ACT_ALLOC) ? stop : in_range_end;
    hi_a     = (end_sel < stop) ? end_sel : stop;
    hi_in    = (hi_a < PG_CAP) ? hi_a : PG_CAP;
    start_in = (in_action == ACT_ALLOC) ? '0 : in_page_index;
  end

  // Word and bit coordinates of the start page and the search end.
  assign sw        = WW'({1'b0, start_r} >> BIT_W);
  assign sb        = start_r[BIT_W-1:0];
  assign hi_w      = WW'(hi_r >> BIT_W);
  assign hb        = hi_r[BIT_W-1:0];
  assign at_start  = (w_r == sw);
  assign w_below   = (w_r < hi_w);
  assign w_at      = (w_r == hi_w);
  assign next_base = {(WW + 1)'(w_r) + (WW + 1)'(1), {BIT_W{1'b0}}};

  // Candidate pages in the current word: the start page itself if it is below the limit
  // and the storage, then pages above it and below the search end.
  always_comb begin
    logic gt_start;
    logic lt_hi;
    cand = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      gt_start = at_start ? (BIT_W'(b) > sb) : 1'b1;
      lt_hi    = w_below | (w_at & (BIT_W'(b) < hb));
      cand[b]  = (gt_start & lt_hi) | (at_start & start_ok_r & (BIT_W'(b) == sb));
    end
  end

  assign free_bits = cand & ~rdata;
  assign hit       = |free_bits;
  assign more      = (next_base < {1'b0, hi_r});

  // Lowest free candidate bit.
  always_comb begin
    hit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_idx = BIT_W'(b);
      end
    end
  end

  assign hit_page = {w_r, hit_idx};

  // Single-page view for free, mark and query.
  assign page_ok  = ({1'b0, start_r} < PG_CAP);
  assign page_bit = rdata[sb];
  assign q_used   = ({1'b0, start_r} >= lim_r) | ~page_ok | page_bit;

  // Write-back word and count update for the held request.
  always_comb begin
    wr_word = rdata;
    wr_ok   = 1'b0;
    cnt_nxt = cnt_r;
    unique case (act_r)
      ACT_ALLOC: begin
        if (hit) begin
          wr_word = rdata | (WORD_BITS'(1) << hit_idx);
          wr_ok   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ACT_FREE: begin
        if (page_ok && page_bit) begin
          wr_word = rdata & ~(WORD_BITS'(1) << sb);
          wr_ok   = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ACT_MARK: begin
        if (page_ok && !page_bit) begin
          wr_word = rdata | (WORD_BITS'(1) << sb);
          wr_ok   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (!cmd.commit) begin
      cnt_nxt = cnt_r;
    end
  end

  // Scan pointer advance.
  assign w_nxt = cmd.load    ? WW'({1'b0, start_in} >> BIT_W) :
                 cmd.rd_next ? w_r + WW'(1) : w_r;

  // RAM port steering: the reset fill owns the write port while it runs.
  assign ram_we    = cmd.clr_step | (cmd.commit & wr_ok);
  assign ram_waddr = cmd.clr_step ? clr_r : AW'(w_r);
  assign ram_wdata = cmd.clr_step ? '1 : wr_word;
  assign ram_raddr = cmd.rd_next ? AW'(w_r + WW'(1)) : AW'(w_r);

  bpfa_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (NUM_WORDS),
    .ADDR_W (AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Control registers: limit, used count and reset fill pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
      cnt_r <= CNT_W'(NUM_PAGES);
      clr_r <= '0;
    end else begin
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
      cnt_r <= cnt_nxt;
      if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  // Request and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r      <= in_action;
      start_r    <= start_in;
      hi_r       <= hi_in;
      start_ok_r <= ({1'b0, start_in} < lim_r) && ({1'b0, start_in} < PG_CAP);
    end
    w_r <= w_nxt;
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r      <= ((act_r == ACT_ALLOC) || (act_r == ACT_FIND)) && hit;
      found_page_r <= (((act_r == ACT_ALLOC) || (act_r == ACT_FIND)) && hit) ?
                      hit_page[PAGE_W-1:0] : '0;
      used_r       <= (act_r == ACT_QUERY) && q_used;
      count_r      <= LIMIT_W'(cnt_nxt);
    end
  end

  assign st.clr_last = (clr_r == AW'(NUM_WORDS - 1));
  assign st.scan     = (act_r == ACT_ALLOC) || (act_r == ACT_FIND);
  assign st.hit      = hit;
  assign st.more     = more;

  assign out_found_page   = found_page_r;
  assign out_found        = found_r;
  assign out_page_is_used = used_r;
  assign out_used_count   = count_r;

  // The used count never exceeds the number of pages.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_PAGES))
    else $error("used page count above page total");

  // A successful alloc claims exactly one page.
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (act_r == ACT_ALLOC) && hit) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("alloc did not raise the used count by one");

  // An allocated page lies below the usable limit.
  a_alloc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (act_r == ACT_ALLOC) && hit) |-> (hit_page < lim_r))
    else $error("alloc returned a page at or above the limit");

endmodule

FILE: rtl/bpfa_ctrl.sv
// Controller of the page frame allocator: reset fill, request acceptance,
// word reads, scan sequencing and result hand-off. Uses bpfa_pkg.
module bpfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bpfa_pkg::dp_status_t st,
  output bpfa_pkg::dp_cmd_t    cmd
);
  import bpfa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register may be reloaded once its transaction leaves.
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (st.scan && !st.hit && st.more) begin
          cmd.rd      = 1'b1;
          cmd.rd_next = 1'b1;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Output valid follows commit and the downstream handshake.
  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> slot_free)
    else $error("result overwritten before it was taken");

  // A result appears only from a commit.
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("output valid without a commit");

  // After a commit the block is idle and presents the result.
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == S_IDLE) && out_valid_r)
    else $error("commit did not return to idle with a result");

endmodule

FILE: rtl/bitmap_page_frame_allocator_unit.sv
// Bitmap page frame allocator, first fit. Free, mark and query read one bitmap word;
// alloc and find read bitmap words, one word per cycle through the single RAM read port,
// from the word of the start page until a free candidate is found or the range ends.
// One request is in flight at a time; the next is accepted the cycle after a result
// is committed, while that result may still wait in the output register.
// After reset a fill pass writes every bitmap word all-used (NUM_PAGES/WORD_BITS words,
// 1024 by default), with in_ready low; configuration writes are taken.
module bitmap_page_frame_allocator_unit #(
  parameter int NUM_PAGES = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bpfa_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpfa_pkg::ACT_W-1:0]    in_action,
  input  logic [bpfa_pkg::PAGE_W-1:0]   in_page_index,
  input  logic [bpfa_pkg::LIMIT_W-1:0]  in_range_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpfa_pkg::PAGE_W-1:0]   out_found_page,
  output logic                          out_found,
  output logic                          out_page_is_used,
  output logic [bpfa_pkg::LIMIT_W-1:0]  out_used_count
);
  import bpfa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencing.
  bpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Bitmap storage, search and accounting.
  bpfa_dp #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_action),
    .in_page_index    (in_page_index),
    .in_range_end     (in_range_end),
    .cmd              (cmd),
    .st               (st),
    .out_found_page   (out_found_page),
    .out_found        (out_found),
    .out_page_is_used (out_page_is_used),
    .out_used_count   (out_used_count)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_frame_allocator_unit.
// Predicts each reply from a bit-per-page map kept here. Depends on bpfa_pkg and the RTL.
module tb_top;
  import bpfa_pkg::*;

  localparam int unsigned PAGE_COUNT = 65536;
  localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;
  localparam int TAIL_CYCLES = 50;
  localparam int CALM_ITEMS = 150;
  localparam int REPORT_MAX = 10;
  localparam int PHASES = 12;

  // A pending stimulus entry is either a request or a new usable limit.
  typedef struct {
    bit                 is_cfg;
    logic [LIMIT_W-1:0] limit;
    logic [ACT_W-1:0]   action;
    logic [PAGE_W-1:0]  page;
    logic [LIMIT_W-1:0] range_end;
  } request_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  found_page;
    logic               found;
    logic               page_is_used;
    logic [LIMIT_W-1:0] used_count;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ACT_W-1:0]   in_action = '0;
  logic [PAGE_W-1:0]  in_page_index = '0;
  logic [LIMIT_W-1:0] in_range_end = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PAGE_W-1:0]  out_found_page;
  logic               out_found;
  logic               out_page_is_used;
  logic [LIMIT_W-1:0] out_used_count;

  request_t    pending[$];
  reply_t      replies_due[$];
  bit          page_map[PAGE_COUNT];
  int unsigned used_total;
  int unsigned limit_now;
  int          mismatch_count = 0;
  bit          in_taken = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          quiet_left = 0;

  // Random phases: mostly small limits keep the scans short, two run at full size.
  int unsigned phase_limit[PHASES] = '{1, 2, 64, 65, 200, 1000, 4096, 0, 513, 2048,
                                       65536, 65535};
  int          phase_items[PHASES] = '{100, 100, 150, 150, 250, 250, 300, 80, 200, 200,
                                       30, 30};

  bitmap_page_frame_allocator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_page_index    (in_page_index),
    .in_range_end     (in_range_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found_page   (out_found_page),
    .out_found        (out_found),
    .out_page_is_used (out_page_is_used),
    .out_used_count   (out_used_count)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pages at or above the limit, or past the map, read as used.
  function automatic bit reads_used(int unsigned p);
    return p >= limit_now || p >= PAGE_COUNT || page_map[p];
  endfunction

  // First-fit scan. The start page is tested before any bound; the scan gives up
  // once the next page reaches the range end or the limit minus one.
  function automatic bit first_free(int unsigned start, longint unsigned scan_end,
                                    output int unsigned where);
    int unsigned stop_at;
    int unsigned p;
    stop_at = (limit_now != 0) ? limit_now - 1 : 0;
    p = start;
    where = 0;
    while (reads_used(p)) begin
      p++;
      if (p >= scan_end || p >= stop_at) return 1'b0;
    end
    where = p;
    return 1'b1;
  endfunction

  function automatic void claim_page(int unsigned p);
    if (p < PAGE_COUNT && !page_map[p]) begin
      page_map[p] = 1'b1;
      used_total++;
    end
  endfunction

  function automatic void clear_page(int unsigned p);
    if (p < PAGE_COUNT && page_map[p]) begin
      page_map[p] = 1'b0;
      used_total--;
    end
  endfunction

  // Applies one request to the page map and returns the reply it should produce.
  function automatic reply_t apply_request(logic [ACT_W-1:0] action, logic [PAGE_W-1:0] page,
                                           logic [LIMIT_W-1:0] range_end);
    reply_t      r;
    bit          ok;
    int unsigned hit;
    r = '0;
    ok = 1'b0;
    hit = 0;
    case (action)
      ACT_ALLOC: begin
        ok = first_free(0, 64'hFFFF_FFFF, hit);
        if (ok) claim_page(hit);
      end
      ACT_FREE:  clear_page(page);
      ACT_MARK:  claim_page(page);
      ACT_QUERY: r.page_is_used = reads_used(page);
      ACT_FIND:  ok = first_free(page, range_end, hit);
      default: ;
    endcase
    r.found = ok;
    r.found_page = ok ? PAGE_W'(hit) : '0;
    r.used_count = LIMIT_W'(used_total);
    return r;
  endfunction

  task automatic add_req(logic [ACT_W-1:0] action, int unsigned page, int unsigned range_end);
    request_t rq;
    rq = '{1'b0, '0, action, PAGE_W'(page), LIMIT_W'(range_end)};
    pending.push_back(rq);
  endtask

  task automatic add_limit(int unsigned value);
    request_t rq;
    rq = '{1'b1, LIMIT_W'(value), '0, '0, '0};
    pending.push_back(rq);
  endtask

  // Most pages land near the usable region, the rest anywhere in the index space.
  function automatic int unsigned pick_page(int unsigned lim);
    int unsigned win;
    win = (lim == 0) ? 64 : lim + 8;
    if (win > PAGE_COUNT) win = PAGE_COUNT;
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, win - 1);
    return $urandom_range(0, PAGE_COUNT - 1);
  endfunction

  function automatic int unsigned pick_end(int unsigned page);
    int unsigned r;
    int unsigned e;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      e = page + $urandom_range(0, 300);
      if (e > PAGE_COUNT) e = PAGE_COUNT;
    end else if (r < 8) begin
      e = $urandom_range(0, PAGE_COUNT);
    end else if (r == 8) begin
      e = PAGE_COUNT;
    end else begin
      e = $urandom_range(0, page);
    end
    return e;
  endfunction

  task automatic add_random_req(int unsigned lim);
    int unsigned      r;
    int unsigned      pg;
    logic [ACT_W-1:0] act;
    r = $urandom_range(0, 99);
    if (r < 25) act = ACT_ALLOC;
    else if (r < 50) act = ACT_FREE;
    else if (r < 62) act = ACT_MARK;
    else if (r < 77) act = ACT_QUERY;
    else if (r < 95) act = ACT_FIND;
    else act = ACT_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    pg = pick_page(lim);
    add_req(act, pg, pick_end(pg));
  endtask

  // One phase: set the limit, then free/find/query/alloc bursts mixed with loose requests.
  task automatic fill_phase(int unsigned lim, int count);
    int          made;
    int          k;
    int unsigned pg;
    add_limit(lim);
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 3) begin
        k = $urandom_range(1, 6);
        pg = pick_page(lim);
        repeat (k) add_req(ACT_FREE, pick_page(lim), $urandom_range(0, PAGE_COUNT));
        add_req(ACT_FIND, pg, pick_end(pg));
        add_req(ACT_QUERY, pg, $urandom_range(0, PAGE_COUNT));
        repeat (k) add_req(ACT_ALLOC, $urandom_range(0, PAGE_COUNT - 1),
                           $urandom_range(0, PAGE_COUNT));
        made += 2 * k + 2;
      end else begin
        add_random_req(lim);
        made++;
      end
    end
  endtask

  // Driver: request channel, configuration port and result-side back-pressure.
  always @(negedge clk) begin
    bit       quiet;
    bit       drive_item;
    bit       write_cfg;
    request_t rq;
    drive_item = 1'b0;
    write_cfg = 1'b0;
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 299) == 0) quiet_left = $urandom_range(50, 200);
    quiet = quiet_left > 0 || pending.size() < CALM_ITEMS;
    if (quiet) begin
      in_gap = 0;
      out_stall = 0;
    end
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // The current transaction has not been accepted yet: hold it.
        drive_item = 1'b1;
      end else begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(0, 9);
        end else if (pending.size() != 0) begin
          if (pending[0].is_cfg) begin
            // The limit changes only once every reply has come back.
            if (replies_due.size() == 0) begin
              rq = pending.pop_front();
              write_cfg = 1'b1;
              cfg_wdata <= rq.limit;
            end
          end else begin
            rq = pending.pop_front();
            drive_item = 1'b1;
            in_action <= rq.action;
            in_page_index <= rq.page;
            in_range_end <= rq.range_end;
          end
        end
      end

      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_stall = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    in_valid <= drive_item;
    cfg_we <= write_cfg;
  end

  // Monitor: predicts on each accepted request and checks each accepted reply.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n) begin
      if (cfg_we) limit_now = cfg_wdata;
      if (in_valid && in_ready) begin
        replies_due.push_back(apply_request(in_action, in_page_index, in_range_end));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = {out_found_page, out_found, out_page_is_used, out_used_count};
        if (replies_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: reply with none outstanding: page %0d found %0b used %0b count %0d",
                     $time, got.found_page, got.found, got.page_is_used, got.used_count);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display({"%0t: reply mismatch (expected/actual): page %0d/%0d found %0b/%0b",
                        " used %0b/%0b count %0d/%0d"}, $time,
                       want.found_page, got.found_page, want.found, got.found,
                       want.page_is_used, got.page_is_used, want.used_count,
                       got.used_count);
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    foreach (page_map[i]) page_map[i] = 1'b1;
    used_total = PAGE_COUNT;
    limit_now = 0;

    // Reset limit of zero: everything reads used and every search fails.
    add_req(ACT_QUERY, 0, 0);
    add_req(ACT_ALLOC, 0, 0);
    add_req(ACT_FIND, 0, PAGE_COUNT);
    add_req(ACT_FREE, 0, 0);
    add_req(ACT_QUERY, 0, 0);
    add_req(ACT_RSVD_LO, 0, 0);
    add_req(ACT_RSVD_HI, PAGE_COUNT - 1, 17'h1FFFF);

    // Full limit: page zero is a valid alloc result, the top page is never reached
    // by a scan but is found when the scan starts on it.
    add_limit(PAGE_COUNT);
    add_req(ACT_ALLOC, 0, 0);
    add_req(ACT_FREE, PAGE_COUNT - 1, 0);
    add_req(ACT_QUERY, PAGE_COUNT - 1, 0);
    add_req(ACT_FIND, 65000, PAGE_COUNT);
    add_req(ACT_FIND, PAGE_COUNT - 1, PAGE_COUNT);
    // A free start page is found even past the range end.
    add_req(ACT_FREE, 100, 0);
    add_req(ACT_FIND, 100, 50);
    add_req(ACT_FIND, 50, 100);
    add_req(ACT_FIND, 50, 101);
    // Repeated mark and free only count once.
    add_req(ACT_MARK, 100, 0);
    add_req(ACT_MARK, 100, 0);
    add_req(ACT_FREE, 100, 0);
    add_req(ACT_FREE, 100, 0);
    add_req(ACT_ALLOC, 0, 0);
    add_req(ACT_ALLOC, 0, 0);

    // Smallest nonzero limits.
    add_limit(1);
    add_req(ACT_FREE, 0, 0);
    add_req(ACT_ALLOC, 0, 0);
    add_limit(2);
    add_req(ACT_FREE, 1, 0);
    add_req(ACT_ALLOC, 0, 0);

    for (int i = 0; i < PHASES; i++) fill_phase(phase_limit[i], phase_items[i]);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
